[hdl/ida_pkg.sv]
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types and constants of the identifier allocator: request and status
// codes, controller states and the fixed field widths.
// ----------------------------------------------------------------------------
package ida_pkg;

  localparam int unsigned MaxIdsDefault = 256;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned EntIdW  = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ActW    = 9;
  localparam int unsigned TotW    = 32;

  localparam logic [ActW-1:0] ActiveMax = '1;

  typedef enum logic [ReqW-1:0] {
    REQ_ALLOC   = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_ENABLE  = 3'd2,
    REQ_DISABLE = 3'd3,
    REQ_DELETE  = 3'd4,
    REQ_COMMIT  = 3'd5,
    REQ_QUERY   = 3'd6
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_PEND_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CMT_RD,
    ST_CMT_WR
  } state_e;

endpackage

[hdl/ida_ram.sv]
// ----------------------------------------------------------------------------
// ida_ram
// Generic single-clock RAM, one write port and one read port, registered read
// data that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module ida_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/id_allocator_deferred_free.sv]
// ----------------------------------------------------------------------------
// id_allocator_deferred_free
// Identifier allocator with LIFO reuse and release deferred until commit.
// ----------------------------------------------------------------------------
// After reset the block sweeps its present and disabled flag memories, one
// entry per cycle, with in_stall_o high. Then it takes one request at a time:
// a request is read from the flag and free-stack memories in the cycle it is
// accepted and written back in ST_EXEC, in the same cycle that its result is
// loaded into the output register; ST_EXEC waits while that register is held
// full by out_stall_i. Commit walks the pending list through its memory port,
// reading each queued id in ST_CMT_RD and pushing it onto the free stack in
// ST_CMT_WR, and holds the block until the list is drained. The output
// register lets the next request be accepted while a result still waits; a
// request only completes once that register is free.
module id_allocator_deferred_free
  import ida_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ReqW-1:0]    in_req_type_i,
  input  logic [EntIdW-1:0]  in_entity_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] out_status_o,
  output logic [EntIdW-1:0]  out_given_id_o,
  output logic               out_is_present_o,
  output logic               out_is_enabled_o,
  output logic [ActW-1:0]    out_active_count_o,
  output logic [TotW-1:0]    out_created_total_o,
  output logic [TotW-1:0]    out_added_total_o,
  output logic [TotW-1:0]    out_deleted_total_o
);

  localparam int unsigned IdW  = $clog2(MAX_IDS);
  localparam int unsigned CntW = $clog2(MAX_IDS + 1);
  localparam int unsigned CmpW = (CntW > EntIdW) ? CntW : EntIdW;

  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_IDS);
  localparam logic [IdW-1:0]  LastIdx = IdW'(MAX_IDS - 1);

  state_e state_q, state_d;

  req_e              req_q;
  logic [EntIdW-1:0] id_q;
  logic [IdW-1:0]    clr_idx_q;
  logic [CntW-1:0]   cmt_idx_q;

  logic [CntW-1:0] next_fresh_q, next_fresh_d;
  logic [CntW-1:0] free_top_q, free_top_d;
  logic [CntW-1:0] pend_cnt_q, pend_cnt_d;
  logic [ActW-1:0] active_q, active_d;
  logic [TotW-1:0] created_q, created_d;
  logic [TotW-1:0] added_q, added_d;
  logic [TotW-1:0] deleted_q, deleted_d;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [EntIdW-1:0]  out_given_q;
  logic               out_present_q;
  logic               out_enabled_q;
  logic [ActW-1:0]    out_active_q;
  logic [TotW-1:0]    out_created_q;
  logic [TotW-1:0]    out_added_q;
  logic [TotW-1:0]    out_deleted_q;

  status_e           status;
  logic [EntIdW-1:0] given;
  logic              res_present;
  logic              res_enabled;

  logic            accept;
  logic            exec_go;
  logic [CmpW-1:0] id_cmp;
  logic            in_range;
  logic [IdW-1:0]  id_idx;
  logic [IdW-1:0]  acc_idx;
  logic [CntW-1:0] free_top_m1;

  // memory ports
  logic           free_we, free_re;
  logic [IdW-1:0] free_rdata;
  logic           pend_we, pend_re;
  logic [IdW-1:0] pend_rdata;
  logic           pres_we, pres_re, pres_wdata, pres_rdata;
  logic           dis_we, dis_re, dis_wdata, dis_rdata;
  logic [IdW-1:0] flag_waddr;

  assign accept      = (state_q == ST_IDLE) && in_valid_i;
  assign exec_go     = !out_valid_q || !out_stall_i;
  assign id_cmp      = CmpW'(id_q);
  assign in_range    = id_cmp < CmpW'(MAX_IDS);
  assign id_idx      = id_cmp[IdW-1:0];
  assign acc_idx     = IdW'(CmpW'(in_entity_id_i));
  assign free_top_m1 = free_top_q - 1'b1;

  ida_ram #(.Width(IdW), .Depth(MAX_IDS)) u_free_stack (
    .clk_i     (clk_i),
    .wr_en_i   (free_we),
    .wr_addr_i (free_top_q[IdW-1:0]),
    .wr_data_i (pend_rdata),
    .rd_en_i   (free_re),
    .rd_addr_i (free_top_m1[IdW-1:0]),
    .rd_data_o (free_rdata)
  );

  ida_ram #(.Width(IdW), .Depth(MAX_IDS)) u_pend_list (
    .clk_i     (clk_i),
    .wr_en_i   (pend_we),
    .wr_addr_i (pend_cnt_q[IdW-1:0]),
    .wr_data_i (id_idx),
    .rd_en_i   (pend_re),
    .rd_addr_i (cmt_idx_q[IdW-1:0]),
    .rd_data_o (pend_rdata)
  );

  ida_ram #(.Width(1), .Depth(MAX_IDS)) u_present (
    .clk_i     (clk_i),
    .wr_en_i   (pres_we),
    .wr_addr_i (flag_waddr),
    .wr_data_i (pres_wdata),
    .rd_en_i   (pres_re),
    .rd_addr_i (acc_idx),
    .rd_data_o (pres_rdata)
  );

  ida_ram #(.Width(1), .Depth(MAX_IDS)) u_disabled (
    .clk_i     (clk_i),
    .wr_en_i   (dis_we),
    .wr_addr_i (flag_waddr),
    .wr_data_i (dis_wdata),
    .rd_en_i   (dis_re),
    .rd_addr_i (acc_idx),
    .rd_data_o (dis_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_e'(in_req_type_i) == REQ_COMMIT) ? ST_CMT_RD : ST_EXEC;
        end
      end
      ST_CMT_RD: begin
        state_d = (cmt_idx_q == pend_cnt_q) ? ST_EXEC : ST_CMT_WR;
      end
      ST_CMT_WR: state_d = ST_CMT_RD;
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // memory controls and request execution
  always_comb begin
    free_we      = 1'b0;
    free_re      = 1'b0;
    pend_we      = 1'b0;
    pend_re      = 1'b0;
    pres_we      = 1'b0;
    pres_re      = 1'b0;
    pres_wdata   = 1'b0;
    dis_we       = 1'b0;
    dis_re       = 1'b0;
    dis_wdata    = 1'b0;
    flag_waddr   = id_idx;
    next_fresh_d = next_fresh_q;
    free_top_d   = free_top_q;
    pend_cnt_d   = pend_cnt_q;
    active_d     = active_q;
    created_d    = created_q;
    added_d      = added_q;
    deleted_d    = deleted_q;
    status       = STAT_OK;
    given        = '0;
    res_present  = pres_rdata;
    res_enabled  = !dis_rdata;
    case (state_q)
      ST_CLEAR: begin
        pres_we    = 1'b1;
        dis_we     = 1'b1;
        flag_waddr = clr_idx_q;
      end
      ST_IDLE: begin
        pres_re = accept;
        dis_re  = accept;
        free_re = accept && (free_top_q != '0);
      end
      ST_CMT_RD: begin
        pend_re = (cmt_idx_q != pend_cnt_q);
      end
      ST_CMT_WR: begin
        // an id that would overflow the free stack is dropped
        free_we    = (free_top_q != MaxCnt);
        free_top_d = free_we ? free_top_q + 1'b1 : free_top_q;
        pres_we    = 1'b1;
        flag_waddr = pend_rdata;
      end
      ST_EXEC: begin
        case (req_q)
          REQ_ALLOC: begin
            if (free_top_q != '0) begin
              given      = EntIdW'(free_rdata);
              free_top_d = free_top_m1;
              created_d  = created_q + 1'b1;
            end else if (next_fresh_q != MaxCnt) begin
              given        = EntIdW'(next_fresh_q[IdW-1:0]);
              next_fresh_d = next_fresh_q + 1'b1;
              created_d    = created_q + 1'b1;
            end else begin
              status = STAT_NO_FREE;
            end
          end
          REQ_ADD, REQ_ENABLE, REQ_DISABLE, REQ_DELETE, REQ_QUERY: begin
            if (!in_range) begin
              status = STAT_RANGE;
            end else if (req_q == REQ_ADD) begin
              pres_we     = 1'b1;
              pres_wdata  = 1'b1;
              dis_we      = 1'b1;
              res_present = 1'b1;
              res_enabled = 1'b1;
              active_d    = (active_q != ActiveMax) ? active_q + 1'b1 : active_q;
              added_d     = added_q + 1'b1;
            end else if (req_q == REQ_ENABLE) begin
              dis_we      = 1'b1;
              res_enabled = 1'b1;
            end else if (req_q == REQ_DISABLE) begin
              dis_we      = 1'b1;
              dis_wdata   = 1'b1;
              res_enabled = 1'b0;
            end else if (req_q == REQ_DELETE) begin
              if (pend_cnt_q == MaxCnt) begin
                status = STAT_PEND_FULL;
              end else begin
                dis_we      = 1'b1;
                pend_we     = 1'b1;
                res_enabled = 1'b1;
                pend_cnt_d  = pend_cnt_q + 1'b1;
                active_d    = (active_q != '0) ? active_q - 1'b1 : active_q;
                deleted_d   = deleted_q + 1'b1;
              end
            end
          end
          REQ_COMMIT: pend_cnt_d = '0;
          default: ;
        endcase
        if (!in_range || req_q == REQ_ALLOC || req_q == REQ_COMMIT ||
            !(req_q == REQ_ADD || req_q == REQ_ENABLE || req_q == REQ_DISABLE ||
              req_q == REQ_DELETE || req_q == REQ_QUERY)) begin
          res_present = 1'b0;
          res_enabled = 1'b0;
        end
        // nothing takes effect until the output register can take the result
        if (!exec_go) begin
          pres_we      = 1'b0;
          dis_we       = 1'b0;
          pend_we      = 1'b0;
          next_fresh_d = next_fresh_q;
          free_top_d   = free_top_q;
          pend_cnt_d   = pend_cnt_q;
          active_d     = active_q;
          created_d    = created_q;
          added_d      = added_q;
          deleted_d    = deleted_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      cmt_idx_q    <= '0;
      next_fresh_q <= '0;
      free_top_q   <= '0;
      pend_cnt_q   <= '0;
      active_q     <= '0;
      created_q    <= '0;
      added_q      <= '0;
      deleted_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_fresh_q <= next_fresh_d;
      free_top_q   <= free_top_d;
      pend_cnt_q   <= pend_cnt_d;
      active_q     <= active_d;
      created_q    <= created_d;
      added_q      <= added_d;
      deleted_q    <= deleted_d;
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
      if (accept) begin
        cmt_idx_q <= '0;
      end else if (state_q == ST_CMT_WR) begin
        cmt_idx_q <= cmt_idx_q + 1'b1;
      end
      if (state_q == ST_EXEC && exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(in_req_type_i);
      id_q  <= in_entity_id_i;
    end
    if (state_q == ST_EXEC && exec_go) begin
      out_status_q  <= status;
      out_given_q   <= given;
      out_present_q <= res_present;
      out_enabled_q <= res_enabled;
      out_active_q  <= active_d;
      out_created_q <= created_d;
      out_added_q   <= added_d;
      out_deleted_q <= deleted_d;
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_given_id_o      = out_given_q;
  assign out_is_present_o    = out_present_q;
  assign out_is_enabled_o    = out_enabled_q;
  assign out_active_count_o  = out_active_q;
  assign out_created_total_o = out_created_q;
  assign out_added_total_o   = out_added_q;
  assign out_deleted_total_o = out_deleted_q;

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without a finished request");

  a_fill_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_top_q <= MaxCnt) && (pend_cnt_q <= MaxCnt) && (next_fresh_q <= MaxCnt))
    else $error("free stack, pending list or fresh counter out of bounds");

  a_commit_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && req_q == REQ_COMMIT && exec_go) |=> (pend_cnt_q == '0))
    else $error("pending list not empty after commit");

  a_commit_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMT_WR) |-> (cmt_idx_q < pend_cnt_q))
    else $error("commit walked past the pending list");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the identifier allocator. A scoreboard object
// keeps its own copy of the free stack, pending list, flags and counters. It
// predicts the result of every accepted request and compares each result from
// the block against it in order. The stimulus starts with a short directed
// list. It then runs random mixes and bursts that exhaust the id space, fill
// the pending list, overflow the free stack on commit and saturate the active
// count. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
  import ida_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumIds      = MaxIdsDefault;
  localparam logic [ReqW-1:0] ReqUnused = 3'd7;
  localparam int unsigned HoldCycles  = 90;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    status_e           status;
    logic [EntIdW-1:0] given_id;
    logic              present;
    logic              enabled;
    logic [ActW-1:0]   active;
    logic [TotW-1:0]   created;
    logic [TotW-1:0]   added;
    logic [TotW-1:0]   deleted;
  } id_result_t;

  class id_scoreboard;
    logic [EntIdW-1:0] free_stk[NumIds];
    logic [EntIdW-1:0] pend_ids[NumIds];
    bit                present_flag[NumIds];
    bit                disabled_flag[NumIds];
    int unsigned       next_fresh;
    int unsigned       free_top;
    int unsigned       pend_cnt;
    logic [ActW-1:0]   active;
    logic [TotW-1:0]   created;
    logic [TotW-1:0]   added;
    logic [TotW-1:0]   deleted;
    id_result_t        exp_q[$];
    int unsigned       errors;
    int unsigned       n_requests;
    int unsigned       n_checked;
    int unsigned       n_no_free;
    int unsigned       n_pend_full;
    int unsigned       n_dropped;
    int unsigned       active_peak;

    function new();
      for (int i = 0; i < NumIds; i++) begin
        present_flag[i]  = 1'b0;
        disabled_flag[i] = 1'b0;
      end
      next_fresh = 0;
      free_top   = 0;
      pend_cnt   = 0;
      active     = '0;
      created    = '0;
      added      = '0;
      deleted    = '0;
      errors     = 0;
      n_requests = 0;
      n_checked  = 0;
      n_no_free  = 0;
      n_pend_full = 0;
      n_dropped  = 0;
      active_peak = 0;
    endfunction

    function int unsigned ids_left();
      return free_top + (NumIds - next_fresh);
    endfunction

    function int unsigned outstanding();
      return exp_q.size();
    endfunction

    // predict the result of one accepted request and queue it
    function void note_request(logic [ReqW-1:0] req, logic [EntIdW-1:0] id);
      id_result_t e;
      bit         show;
      show       = 1'b0;
      e.status   = STAT_OK;
      e.given_id = '0;
      n_requests++;
      case (req)
        REQ_ALLOC: begin
          if (free_top > 0) begin
            free_top--;
            e.given_id = free_stk[free_top];
            created++;
          end else if (next_fresh < NumIds) begin
            e.given_id = EntIdW'(next_fresh);
            next_fresh++;
            created++;
          end else begin
            e.status = STAT_NO_FREE;
            n_no_free++;
          end
        end
        REQ_ADD, REQ_ENABLE, REQ_DISABLE, REQ_DELETE, REQ_QUERY: begin
          if (int'(id) >= NumIds) begin
            e.status = STAT_RANGE;
          end else begin
            show = 1'b1;
            if (req == REQ_ADD) begin
              present_flag[id]  = 1'b1;
              disabled_flag[id] = 1'b0;
              if (active != ActiveMax) active++;
              added++;
            end else if (req == REQ_ENABLE) begin
              disabled_flag[id] = 1'b0;
            end else if (req == REQ_DISABLE) begin
              disabled_flag[id] = 1'b1;
            end else if (req == REQ_DELETE) begin
              if (pend_cnt >= NumIds) begin
                e.status = STAT_PEND_FULL;
                n_pend_full++;
              end else begin
                disabled_flag[id] = 1'b0;
                pend_ids[pend_cnt] = id;
                pend_cnt++;
                if (active != '0) active--;
                deleted++;
              end
            end
          end
        end
        REQ_COMMIT: begin
          // queue order onto the stack, ids past a full stack are lost
          for (int i = 0; i < pend_cnt; i++) begin
            if (free_top < NumIds) begin
              free_stk[free_top] = pend_ids[i];
              free_top++;
            end else begin
              n_dropped++;
            end
            present_flag[pend_ids[i]] = 1'b0;
          end
          pend_cnt = 0;
        end
        default: ;
      endcase
      e.present = show ? present_flag[id] : 1'b0;
      e.enabled = show ? ~disabled_flag[id] : 1'b0;
      e.active  = active;
      e.created = created;
      e.added   = added;
      e.deleted = deleted;
      if (active > active_peak) active_peak = active;
      exp_q.insert(exp_q.size(), e);
    endfunction

    function void check_result(id_result_t got);
      id_result_t e;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result with no request waiting: st=%0d id=%0d", $realtime,
                   got.status, got.given_id);
        return;
      end
      e = exp_q.pop_front();
      n_checked++;
      if (got.status !== e.status || got.given_id !== e.given_id ||
          got.present !== e.present || got.enabled !== e.enabled ||
          got.active !== e.active || got.created !== e.created ||
          got.added !== e.added || got.deleted !== e.deleted) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result %0d mismatch", $realtime, n_checked);
          $display("  exp st=%0d id=%0d pr=%0b en=%0b act=%0d cr=%0d ad=%0d de=%0d",
                   e.status, e.given_id, e.present, e.enabled, e.active, e.created,
                   e.added, e.deleted);
          $display("  got st=%0d id=%0d pr=%0b en=%0b act=%0d cr=%0d ad=%0d de=%0d",
                   got.status, got.given_id, got.present, got.enabled, got.active,
                   got.created, got.added, got.deleted);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ReqW-1:0]    in_req_type_i;
  logic [EntIdW-1:0]  in_entity_id_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatusW-1:0] out_status_o;
  logic [EntIdW-1:0]  out_given_id_o;
  logic               out_is_present_o;
  logic               out_is_enabled_o;
  logic [ActW-1:0]    out_active_count_o;
  logic [TotW-1:0]    out_created_total_o;
  logic [TotW-1:0]    out_added_total_o;
  logic [TotW-1:0]    out_deleted_total_o;

  id_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  id_allocator_deferred_free #(
    .MAX_IDS(NumIds)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_req_type_i      (in_req_type_i),
    .in_entity_id_i     (in_entity_id_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_given_id_o     (out_given_id_o),
    .out_is_present_o   (out_is_present_o),
    .out_is_enabled_o   (out_is_enabled_o),
    .out_active_count_o (out_active_count_o),
    .out_created_total_o(out_created_total_o),
    .out_added_total_o  (out_added_total_o),
    .out_deleted_total_o(out_deleted_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results still waiting", sb.outstanding());
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall, or one long hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (rx_idle_on) begin
        out_stall_i <= ($urandom_range(0, 99) < 38);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    id_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status   = status_e'(out_status_o);
      got.given_id = out_given_id_o;
      got.present  = out_is_present_o;
      got.enabled  = out_is_enabled_o;
      got.active   = out_active_count_o;
      got.created  = out_created_total_o;
      got.added    = out_added_total_o;
      got.deleted  = out_deleted_total_o;
      sb.check_result(got);
    end
  end

  task automatic send_req(logic [ReqW-1:0] req, logic [EntIdW-1:0] id);
    while (tx_idle_on && $urandom_range(0, 99) < 38) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    in_req_type_i  <= req;
    in_entity_id_i <= id;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, id);
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // mostly low ids so that allocated ids get added, flagged and deleted
  task automatic run_mixed(int unsigned n);
    int unsigned       pick;
    logic [ReqW-1:0]   req;
    logic [EntIdW-1:0] id;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 24)      req = REQ_ALLOC;
      else if (pick < 44) req = REQ_ADD;
      else if (pick < 52) req = REQ_ENABLE;
      else if (pick < 60) req = REQ_DISABLE;
      else if (pick < 76) req = REQ_DELETE;
      else if (pick < 84) req = REQ_COMMIT;
      else if (pick < 97) req = REQ_QUERY;
      else                req = ReqUnused;
      if ($urandom_range(0, 99) < 60) id = EntIdW'($urandom_range(0, 23));
      else id = EntIdW'($urandom());
      send_req(req, id);
    end
  endtask

  initial begin
    int unsigned n;
    sb             = new();
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    hold_req       = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_type_i  = REQ_QUERY;
    in_entity_id_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: fresh ids, flag updates, deferred release, unused code
    send_req(REQ_ALLOC, 8'hff);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ADD, 8'h00);
    send_req(REQ_ADD, 8'hff);
    send_req(REQ_QUERY, 8'hff);
    send_req(REQ_DISABLE, 8'hff);
    send_req(REQ_QUERY, 8'hff);
    send_req(REQ_ENABLE, 8'hff);
    send_req(REQ_DISABLE, 8'h00);
    send_req(REQ_DELETE, 8'h00);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_COMMIT, 8'h5a);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_ALLOC, 8'ha5);
    send_req(ReqUnused, 8'hff);
    // deletes of ids never added drive the active count to its floor
    send_req(REQ_DELETE, 8'hc8);
    send_req(REQ_DELETE, 8'hc9);
    send_req(REQ_DELETE, 8'hc9);
    send_req(REQ_COMMIT, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);

    run_mixed(40);

    // long hold-off on the result side while requests keep coming
    hold_req = 1'b1;
    run_mixed(30);
    wait_results_done();

    // use up every id, then ask for more
    n = sb.ids_left() + 4;
    repeat (n) send_req(REQ_ALLOC, EntIdW'($urandom()));

    // back-to-back adds past the active count ceiling
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (520) send_req(REQ_ADD, EntIdW'($urandom()));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_results_done();

    // fill the pending list, then overflow the free stack on commit
    repeat (NumIds + 3) send_req(REQ_DELETE, EntIdW'($urandom()));
    send_req(REQ_COMMIT, '0);
    repeat (8) send_req(REQ_DELETE, EntIdW'($urandom()));
    send_req(REQ_COMMIT, '1);
    repeat (16) send_req(REQ_ALLOC, '0);

    run_mixed(30);
    wait_results_done();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests, %0d results checked, %0d mismatches", sb.n_requests,
             sb.n_checked, sb.errors);
    $display("no-free %0d, pending-full %0d, dropped on commit %0d, active peak %0d",
             sb.n_no_free, sb.n_pend_full, sb.n_dropped, sb.active_peak);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ida_pkg.sv
hdl/ida_ram.sv
hdl/id_allocator_deferred_free.sv
sim/tb_top.sv
